// ===== rtl/vmau_pkg.sv =====
// ----------------------------------------------------------------------------
// vmau_pkg: shared types and constants of the vector magnitude and angle unit
// Payload structs, fixed-point formats, pipeline depths and the arctangent table.
// ----------------------------------------------------------------------------
package vmau_pkg;

  // Angle output format: unsigned degrees with FRACTION_BITS fraction bits
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ANGLE_BITS    = 9 + FRACTION_BITS;

  // Datapath formats
  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned WORD_BITS    = 64;
  localparam int unsigned PRE_SHIFT    = 28;
  localparam int unsigned CORDIC_ITERS = 56;
  localparam int unsigned QUOT_BITS    = 40;
  localparam int unsigned REM_BITS     = 63;
  localparam int unsigned PROD_BITS    = QUOT_BITS + 8;
  localparam int unsigned SQRT_STAGES  = 32;

  // Pipeline depths, counted in register stages
  localparam int unsigned CORDIC_LAT = CORDIC_ITERS + 1 + QUOT_BITS + 1;
  localparam int unsigned MAG_LAT    = 2 + SQRT_STAGES;
  localparam int unsigned MAG_DELAY  = CORDIC_LAT - MAG_LAT;

  // pi and friends in Q60 radians
  localparam logic [WORD_BITS-1:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [WORD_BITS-1:0] HALF_PI_Q60 = PI_Q60 >> 1;
  localparam logic [WORD_BITS-1:0] ONE_Q60     = 64'd1 << 60;

  // Turn constants in output angle units, one bit wider for wrap handling
  localparam logic [ANGLE_BITS:0] QUARTER_TURN = (ANGLE_BITS + 1)'(90) << FRACTION_BITS;
  localparam logic [ANGLE_BITS:0] HALF_TURN    = (ANGLE_BITS + 1)'(180) << FRACTION_BITS;
  localparam logic [ANGLE_BITS:0] THREE_QUARTER_TURN =
    (ANGLE_BITS + 1)'(270) << FRACTION_BITS;
  localparam logic [ANGLE_BITS:0] FULL_TURN    = (ANGLE_BITS + 1)'(360) << FRACTION_BITS;

  // Largest root of two squared 32-bit magnitudes
  localparam logic [COORD_BITS-1:0] MAG_MAX = 32'd3037000499;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
  } vmau_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] magnitude;
    logic [ANGLE_BITS-1:0] angle_deg;
  } vmau_out_t;

  // Divide by the odd number 2k+1, for the elaboration-time series only
  function automatic logic [WORD_BITS-1:0] div_odd(input logic [WORD_BITS-1:0] v,
                                                   input int k);
    logic [WORD_BITS-1:0] d;
    unique case (k)
      0:  d = v;
      1:  d = v / 3;
      2:  d = v / 5;
      3:  d = v / 7;
      4:  d = v / 9;
      5:  d = v / 11;
      6:  d = v / 13;
      7:  d = v / 15;
      8:  d = v / 17;
      9:  d = v / 19;
      10: d = v / 21;
      11: d = v / 23;
      12: d = v / 25;
      13: d = v / 27;
      14: d = v / 29;
      15: d = v / 31;
      16: d = v / 33;
      17: d = v / 35;
      18: d = v / 37;
      19: d = v / 39;
      20: d = v / 41;
      21: d = v / 43;
      22: d = v / 45;
      23: d = v / 47;
      24: d = v / 49;
      25: d = v / 51;
      26: d = v / 53;
      27: d = v / 55;
      28: d = v / 57;
      29: d = v / 59;
      30: d = v / 61;
      default: d = '0;
    endcase
    return d;
  endfunction

  // atan(2^-i) in Q60: truncated alternating series, atan(1) from pi
  function automatic logic [WORD_BITS-1:0] atan_q60(input int i);
    logic [WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0] term;
    int sh;
    acc = '0;
    if (i == 0) begin
      return PI_Q60 >> 2;
    end
    for (int k = 0; k < 31; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 61) begin
        term = div_odd(ONE_Q60 >> sh, k);
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/vmau_isqrt.sv =====
// ----------------------------------------------------------------------------
// vmau_isqrt: pipelined integer square root
// One result bit per stage, digit-by-digit with a running remainder.
// ----------------------------------------------------------------------------
module vmau_isqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [vmau_pkg::WORD_BITS-1:0]  rad_i,
  output logic [vmau_pkg::COORD_BITS-1:0] root_o
);
  import vmau_pkg::*;

  logic [WORD_BITS-1:0] rem_s [SQRT_STAGES+1];
  logic [WORD_BITS-1:0] res_s [SQRT_STAGES+1];

  assign rem_s[0] = rad_i;
  assign res_s[0] = '0;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [WORD_BITS-1:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - j));

    logic [WORD_BITS-1:0] rem_q;
    logic [WORD_BITS-1:0] res_q;
    logic [WORD_BITS-1:0] trial;

    assign trial = res_s[j] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_s[j] >= trial) begin
          rem_q <= rem_s[j] - trial;
          res_q <= (res_s[j] >> 1) + BIT;
        end else begin
          rem_q <= rem_s[j];
          res_q <= res_s[j] >> 1;
        end
      end
    end

    assign rem_s[j+1] = rem_q;
    assign res_s[j+1] = res_q;
  end

  assign root_o = res_s[SQRT_STAGES][COORD_BITS-1:0];

endmodule

// ===== rtl/vmau_cordic.sv =====
// ----------------------------------------------------------------------------
// vmau_cordic: first-quadrant angle of (ax, ay) in degrees
// Unrolled vectoring CORDIC, clamp, radian-to-degree division and scaling.
// ----------------------------------------------------------------------------
module vmau_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [vmau_pkg::COORD_BITS-1:0] ax_i,
  input  logic [vmau_pkg::COORD_BITS-1:0] ay_i,
  output logic [vmau_pkg::ANGLE_BITS-1:0] theta_o
);
  import vmau_pkg::*;

  // Rotation stages
  logic signed [WORD_BITS-1:0] xs [CORDIC_ITERS+1];
  logic signed [WORD_BITS-1:0] ys [CORDIC_ITERS+1];
  logic signed [WORD_BITS-1:0] zs [CORDIC_ITERS+1];

  assign xs[0] = signed'(WORD_BITS'(ax_i) << PRE_SHIFT);
  assign ys[0] = signed'(WORD_BITS'(ay_i) << PRE_SHIFT);
  assign zs[0] = '0;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
    localparam logic signed [WORD_BITS-1:0] ATAN_C = signed'(atan_q60(i));

    logic signed [WORD_BITS-1:0] x_q;
    logic signed [WORD_BITS-1:0] y_q;
    logic signed [WORD_BITS-1:0] z_q;

    // Rotate clockwise while y is non-negative
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ys[i][WORD_BITS-1]) begin
          x_q <= xs[i] + (ys[i] >>> i);
          y_q <= ys[i] - (xs[i] >>> i);
          z_q <= zs[i] + ATAN_C;
        end else begin
          x_q <= xs[i] - (ys[i] >>> i);
          y_q <= ys[i] + (xs[i] >>> i);
          z_q <= zs[i] - ATAN_C;
        end
      end
    end

    assign xs[i+1] = x_q;
    assign ys[i+1] = y_q;
    assign zs[i+1] = z_q;
  end

  // Clamp to [0, pi/2]
  logic [REM_BITS-1:0] zc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (zs[CORDIC_ITERS][WORD_BITS-1]) begin
        zc_q <= '0;
      end else if (zs[CORDIC_ITERS] > signed'(HALF_PI_Q60)) begin
        zc_q <= REM_BITS'(HALF_PI_Q60);
      end else begin
        zc_q <= REM_BITS'(zs[CORDIC_ITERS]);
      end
    end
  end

  // Quotient z * 2^40 / pi, one bit per stage
  logic [REM_BITS-1:0]  rs [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] qs [QUOT_BITS+1];

  assign rs[0] = zc_q;
  assign qs[0] = '0;

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    logic [REM_BITS-1:0]  r_q;
    logic [QUOT_BITS-1:0] q_q;
    logic [REM_BITS-1:0]  sh;

    // Remainder stays below pi, so the top bit is always clear
    assign sh = {rs[j][REM_BITS-2:0], 1'b0};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sh >= REM_BITS'(PI_Q60)) begin
          r_q <= sh - REM_BITS'(PI_Q60);
          q_q <= {qs[j][QUOT_BITS-2:0], 1'b1};
        end else begin
          r_q <= sh;
          q_q <= {qs[j][QUOT_BITS-2:0], 1'b0};
        end
      end
    end

    assign rs[j+1] = r_q;
    assign qs[j+1] = q_q;
  end

  // Scale half-turn fraction to degrees
  logic [PROD_BITS-1:0] prod;
  logic [ANGLE_BITS-1:0] theta_q;

  assign prod = PROD_BITS'(qs[QUOT_BITS]) * PROD_BITS'(180);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q <= ANGLE_BITS'(prod >> (QUOT_BITS - FRACTION_BITS));
    end
  end

  assign theta_o = theta_q;

endmodule

// ===== rtl/vector_magnitude_and_angle_unit.sv =====
// ----------------------------------------------------------------------------
// vector_magnitude_and_angle_unit: cartesian to polar conversion
// Q16.16 point in; truncated magnitude and direction in degrees out.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled;
//   the pipeline is 100 registers deep, set by the 56 unrolled CORDIC
//   stages and the 40 degree-conversion stages.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
// Reset clears the valid bits only; no state is kept between transactions.
module vector_magnitude_and_angle_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vmau_pkg::vmau_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vmau_pkg::vmau_out_t out_data_o
);
  import vmau_pkg::*;

  // Sign and zero flags that pick the quadrant at the end
  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_zero;
    logic y_neg;
  } vmau_flags_t;

  // Global advance: move every stage when the output register is free or
  // being drained this cycle.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Valid bits travel alongside the data; bit 0 is the input stage
  logic [CORDIC_LAT:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[CORDIC_LAT-1:0], in_valid_i};
      out_valid_q <= vld_q[CORDIC_LAT];
    end
  end

  // Input stage: absolute values and flags
  logic [COORD_BITS-1:0] ax_d, ay_d;
  logic [COORD_BITS-1:0] a_ax_q, a_ay_q;
  vmau_flags_t           flags_d, a_flags_q;

  // Negating the most negative value gives 2^31, which fits unsigned
  assign ax_d = in_data_i.x_coord[COORD_BITS-1] ? (~in_data_i.x_coord + 1'b1)
                                                : in_data_i.x_coord;
  assign ay_d = in_data_i.y_coord[COORD_BITS-1] ? (~in_data_i.y_coord + 1'b1)
                                                : in_data_i.y_coord;

  assign flags_d.x_zero = (in_data_i.x_coord == '0);
  assign flags_d.x_neg  = in_data_i.x_coord[COORD_BITS-1];
  assign flags_d.y_zero = (in_data_i.y_coord == '0);
  assign flags_d.y_neg  = in_data_i.y_coord[COORD_BITS-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q    <= ax_d;
      a_ay_q    <= ay_d;
      a_flags_q <= flags_d;
    end
  end

  // Magnitude path: squares, sum, then the root pipeline
  logic [WORD_BITS-1:0]  sqx_q, sqy_q, sum_q;
  logic [COORD_BITS-1:0] root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= WORD_BITS'(a_ax_q) * WORD_BITS'(a_ax_q);
      sqy_q <= WORD_BITS'(a_ay_q) * WORD_BITS'(a_ay_q);
      sum_q <= sqx_q + sqy_q;
    end
  end

  vmau_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  // Hold the root until the angle catches up
  logic [COORD_BITS-1:0] mag_dly_q [MAG_DELAY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_dly_q[0] <= root;
      for (int k = 1; k < MAG_DELAY; k++) begin
        mag_dly_q[k] <= mag_dly_q[k-1];
      end
    end
  end

  // Angle path: first-quadrant angle in degrees
  logic [ANGLE_BITS-1:0] theta;

  vmau_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .ax_i    (a_ax_q),
    .ay_i    (a_ay_q),
    .theta_o (theta)
  );

  // Carry the flags alongside the angle pipeline
  vmau_flags_t fl_q [CORDIC_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= a_flags_q;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // Quadrant placement. Points on the y axis take 90 or 270 directly (the
  // origin lands on 270); a point on the x axis takes a first-quadrant angle of zero.
  vmau_flags_t           fl;
  logic [ANGLE_BITS:0]   th;
  logic [ANGLE_BITS:0]   ang_raw;
  logic [ANGLE_BITS:0]   ang;
  logic                  y_pos;

  assign fl    = fl_q[CORDIC_LAT-1];
  assign th    = fl.y_zero ? '0 : (ANGLE_BITS + 1)'(theta);
  assign y_pos = !fl.y_zero && !fl.y_neg;

  always_comb begin
    priority if (fl.x_zero) begin
      ang_raw = y_pos ? QUARTER_TURN : THREE_QUARTER_TURN;
    end else if (!fl.x_neg) begin
      ang_raw = fl.y_neg ? (FULL_TURN - th) : th;
    end else begin
      ang_raw = fl.y_neg ? (HALF_TURN + th) : (HALF_TURN - th);
    end
    // Wrap a full turn back to zero
    ang = (ang_raw >= FULL_TURN) ? (ang_raw - FULL_TURN) : ang_raw;
  end

  // Output register
  vmau_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.magnitude <= mag_dly_q[MAG_DELAY-1];
      out_q.angle_deg <= ang[ANGLE_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/vmau_checker.sv =====
// ----------------------------------------------------------------------------
// vmau_checker: port-level checks of the vector magnitude and angle unit
// Watches the top level's ports and reports violations.
// ----------------------------------------------------------------------------
module vmau_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vmau_pkg::vmau_out_t out_data_o
);
  import vmau_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An empty output never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Angle always below a full turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ANGLE_BITS + 1)'(out_data_o.angle_deg) < FULL_TURN)
    else $error("angle out of range");

  // Magnitude bounded by the largest possible root
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.magnitude <= MAG_MAX)
    else $error("magnitude out of range");

endmodule

bind vector_magnitude_and_angle_unit vmau_checker u_vmau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
